[sv/tcw_pkg.sv]
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W   = $clog2(ROWS);

  // field widths of the channels
  localparam int OPCODE_W   = 2;
  localparam int CHAR_W     = 8;
  localparam int RD_ROW_W   = 5;
  localparam int RD_COL_W   = 7;
  localparam int WORD_W     = 16;
  localparam int CUR_COL_W  = 7;
  localparam int CUR_ROW_W  = 5;
  localparam int ATTR_W     = 8;

  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } opcode_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_FILL,
    S_MOVE,
    S_DRAIN,
    S_BLANK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic capture;      // latch the accepted item
    logic exec;         // cursor update, single-cell write, sweep setup
    logic fill;         // blank the cell at the sweep counter
    logic fill_init;    // blank value of the power-up clear
    logic move_step;    // scroll: read the cell one row below
    logic blank_init;   // point the sweep counter at the bottom row
    logic cap_word;     // take the read data into the result word
    logic load_result;  // load the output register
  } cmd_t;

  typedef struct packed {
    logic op_clear;
    logic op_read;
    logic need_scroll;
    logic read_hit;
    logic sweep_last;
    logic out_free;
  } status_t;

endpackage

[sv/tcw_in_if.sv]
interface tcw_in_if import tcw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [CHAR_W-1:0]   char_code;
  logic [RD_ROW_W-1:0] read_row;
  logic [RD_COL_W-1:0] read_col;

  modport source (output valid, opcode, char_code, read_row, read_col, input ready);
  modport sink   (input valid, opcode, char_code, read_row, read_col, output ready);
endinterface

[sv/tcw_out_if.sv]
interface tcw_out_if import tcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WORD_W-1:0]    cell_word;
  logic [CUR_COL_W-1:0] cursor_col;
  logic [CUR_ROW_W-1:0] cursor_row;
  logic                 scrolled;

  modport source (output valid, cell_word, cursor_col, cursor_row, scrolled, input ready);
  modport sink   (input valid, cell_word, cursor_col, cursor_row, scrolled, output ready);
endinterface

[sv/tcw_ram.sv]
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/tcw_ctrl.sv]
module tcw_ctrl import tcw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.fill      = 1'b1;
        cmd_o.fill_init = 1'b1;
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.op_clear) begin
          state_d = S_FILL;
        end else if (sts_i.need_scroll) begin
          state_d = S_MOVE;
        end else if (sts_i.op_read && sts_i.read_hit) begin
          state_d = S_RDWAIT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RDWAIT: begin
        cmd_o.cap_word = 1'b1;
        state_d        = S_DONE;
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.sweep_last) state_d = S_DONE;
      end
      S_MOVE: begin
        cmd_o.move_step = 1'b1;
        if (sts_i.sweep_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        // last moved cell is written by the datapath this cycle
        cmd_o.blank_init = 1'b1;
        state_d          = S_BLANK;
      end
      S_BLANK: begin
        cmd_o.fill = 1'b1;
        if (sts_i.sweep_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[sv/tcw_datapath.sv]
module tcw_datapath import tcw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              sts_o,
  input  logic                 cfg_we_i,
  input  logic [ATTR_W-1:0]    cfg_wdata_i,
  input  logic [OPCODE_W-1:0]  opcode_i,
  input  logic [CHAR_W-1:0]    char_code_i,
  input  logic [RD_ROW_W-1:0]  read_row_i,
  input  logic [RD_COL_W-1:0]  read_col_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WORD_W-1:0]    cell_word_o,
  output logic [CUR_COL_W-1:0] cursor_col_o,
  output logic [CUR_ROW_W-1:0] cursor_row_o,
  output logic                 scrolled_o,
  output logic                 ram_we_o,
  output logic [ADDR_W-1:0]    ram_waddr_o,
  output logic [WORD_W-1:0]    ram_wdata_o,
  output logic                 ram_re_o,
  output logic [ADDR_W-1:0]    ram_raddr_o,
  input  logic [WORD_W-1:0]    ram_rdata_i
);

  // control state
  logic [ATTR_W-1:0] attr_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic              scroll_q, scroll_d;
  logic              out_valid_q;

  // payload
  logic [OPCODE_W-1:0]  op_q;
  logic [CHAR_W-1:0]    ch_q;
  logic [RD_ROW_W-1:0]  rd_row_q;
  logic [RD_COL_W-1:0]  rd_col_q;
  logic [ADDR_W-1:0]    pend_addr_q, pend_addr_d;
  logic [WORD_W-1:0]    word_q, word_d;
  logic [WORD_W-1:0]    cell_word_q;
  logic [CUR_COL_W-1:0] cursor_col_q;
  logic [CUR_ROW_W-1:0] cursor_row_q;
  logic                 scrolled_q;

  logic              is_nl, is_cr, is_bs, is_print;
  logic              col_last, row_last;
  logic              op_put, op_clear, op_read, read_hit, need_scroll, out_free;
  logic [ADDR_W-1:0] cur_addr, rd_addr;
  logic [WORD_W-1:0] fill_word, blank_word;

  assign is_nl    = (ch_q == CH_NEWLINE);
  assign is_cr    = (ch_q == CH_RETURN);
  assign is_bs    = (ch_q == CH_BACKSPACE);
  assign is_print = !(is_nl || is_cr || is_bs);

  assign col_last = (col_q == COL_W'(COLUMNS - 1));
  assign row_last = (row_q == ROW_W'(ROWS - 1));

  assign op_put   = (op_q == OP_PUT);
  assign op_clear = (op_q == OP_CLEAR);
  assign op_read  = (op_q == OP_READ);
  assign read_hit = (rd_row_q < ROWS) && (rd_col_q < COLUMNS);
  assign need_scroll = op_put && row_last && (is_nl || (is_print && col_last));
  assign out_free = !out_valid_q || out_ready_i;

  assign cur_addr = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
  assign rd_addr  = ADDR_W'(rd_row_q) * ADDR_W'(COLUMNS) + ADDR_W'(rd_col_q);

  assign blank_word = {attr_q, BLANK_CHAR};
  assign fill_word  = cmd_i.fill_init ? {ATTR_RESET, BLANK_CHAR} : blank_word;

  always_comb begin
    sts_o             = '0;
    sts_o.op_clear    = op_clear;
    sts_o.op_read     = op_read;
    sts_o.need_scroll = need_scroll;
    sts_o.read_hit    = read_hit;
    sts_o.sweep_last  = (cnt_q == ADDR_W'(CELLS - 1));
    sts_o.out_free    = out_free;
  end

  // memory ports; the pending scroll write never meets a fill or an exec write
  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = cnt_q;
    ram_wdata_o = fill_word;
    if (pend_q) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = pend_addr_q;
      ram_wdata_o = ram_rdata_i;
    end else if (cmd_i.fill) begin
      ram_we_o = 1'b1;
    end else if (cmd_i.exec && op_put) begin
      if (is_print) begin
        ram_we_o    = 1'b1;
        ram_waddr_o = cur_addr;
        ram_wdata_o = {attr_q, ch_q};
      end else if (is_bs && (col_q != '0)) begin
        ram_we_o    = 1'b1;
        ram_waddr_o = cur_addr - ADDR_W'(1);
        ram_wdata_o = blank_word;
      end
    end
  end

  assign ram_re_o    = cmd_i.move_step || (cmd_i.exec && op_read && read_hit);
  assign ram_raddr_o = cmd_i.move_step ? cnt_q : rd_addr;

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    cnt_d       = cnt_q;
    scroll_d    = scroll_q;
    word_d      = word_q;
    pend_d      = cmd_i.move_step;
    pend_addr_d = cnt_q - ADDR_W'(COLUMNS);
    if (cmd_i.fill || cmd_i.move_step) cnt_d = cnt_q + ADDR_W'(1);
    if (cmd_i.blank_init) cnt_d = ADDR_W'((ROWS - 1) * COLUMNS);
    if (cmd_i.cap_word) word_d = ram_rdata_i;
    if (cmd_i.exec) begin
      scroll_d = need_scroll;
      word_d   = '0;
      if (op_clear) begin
        col_d = '0;
        row_d = '0;
        cnt_d = '0;
      end else if (op_put) begin
        if (is_nl) begin
          col_d = '0;
          if (!row_last) row_d = row_q + ROW_W'(1);
        end else if (is_cr) begin
          col_d = '0;
        end else if (is_bs) begin
          if (col_q != '0) col_d = col_q - COL_W'(1);
        end else if (col_last) begin
          col_d = '0;
          if (!row_last) row_d = row_q + ROW_W'(1);
        end else begin
          col_d = col_q + COL_W'(1);
        end
        if (need_scroll) cnt_d = ADDR_W'(COLUMNS);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= ATTR_RESET;
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      scroll_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) attr_q <= cfg_wdata_i;
      col_q    <= col_d;
      row_q    <= row_d;
      cnt_q    <= cnt_d;
      pend_q   <= pend_d;
      scroll_q <= scroll_d;
      if (cmd_i.load_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= opcode_i;
      ch_q     <= char_code_i;
      rd_row_q <= read_row_i;
      rd_col_q <= read_col_i;
    end
    pend_addr_q <= pend_addr_d;
    word_q      <= word_d;
    if (cmd_i.load_result) begin
      cell_word_q  <= word_q;
      cursor_col_q <= CUR_COL_W'(col_q);
      cursor_row_q <= CUR_ROW_W'(row_q);
      scrolled_q   <= scroll_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_word_o  = cell_word_q;
  assign cursor_col_o = cursor_col_q;
  assign cursor_row_o = cursor_row_q;
  assign scrolled_o   = scrolled_q;

`ifndef NO_ASSERTIONS
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q < COLUMNS) && (row_q < ROWS))
    else $error("cursor out of screen");

  a_write_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !cmd_i.fill && !cmd_i.exec)
    else $error("scroll write collides with another write");

  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_result && scroll_q) |-> row_last)
    else $error("scrolled result not on the last row");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_result |-> out_free)
    else $error("result overwrites an untaken transaction");
`endif

endmodule

[sv/text_console_writer_top.sv]
// Each accepted item is executed, then its result is loaded for output; an
// in-range read also waits for the RAM read data. Input is ready again the
// cycle after the result loads. A scroll adds a sweep of the screen RAM through
// its single write port: moves of each row up by one, a drain step and the
// blanking of the bottom row. A clear blanks every cell. After reset the RAM is
// swept to blanks (attribute 0x07) before the first item is accepted.
module text_console_writer_top import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ATTR_W-1:0] cfg_wdata_i,
  tcw_in_if.sink            in_i,
  tcw_out_if.source         out_o
);

  cmd_t              cmd;
  status_t           sts;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcw_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .opcode_i     (in_i.opcode),
    .char_code_i  (in_i.char_code),
    .read_row_i   (in_i.read_row),
    .read_col_i   (in_i.read_col),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .cell_word_o  (out_o.cell_word),
    .cursor_col_o (out_o.cursor_col),
    .cursor_row_o (out_o.cursor_row),
    .scrolled_o   (out_o.scrolled),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  tcw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CELLS),
    .AW    (ADDR_W)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

[tb/text_console_writer_top_test.sv]
module text_console_writer_top_test;
  import tcw_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 234;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [CHAR_W-1:0]   char_code;
    logic [RD_ROW_W-1:0] read_row;
    logic [RD_COL_W-1:0] read_col;
  } console_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]    cell_word;
    logic [CUR_COL_W-1:0] cursor_col;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic                 scrolled;
  } console_result_t;

  typedef struct {
    console_item_t   item;
    int              reps;
    bit              known;
    console_result_t res;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;

  tcw_in_if  char_if ();
  tcw_out_if resp_if ();

  // expectation typed into the stimulus table, travels with the transaction
  logic            row_known;
  console_result_t row_expect;

  logic [WORD_W-1:0] screen_model [CELLS];
  int unsigned       cur_col;
  int unsigned       cur_row;
  logic [ATTR_W-1:0] attr_model;

  console_result_t expected_q [$];
  stim_row_t       stim_rows [$];
  console_result_t want;
  console_result_t got;
  console_item_t   seen;
  int              fail_count = 0;
  int              items_sent = 0;
  bit              calm = 1'b0;

  text_console_writer_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (char_if),
    .out_o       (resp_if)
  );

  always #5 clk = ~clk;

  initial begin
    #200000000;
    $display("[text_console_writer_top] ERROR");
    $finish;
  end

  function automatic logic [WORD_W-1:0] blank_word();
    return {attr_model, BLANK_CHAR};
  endfunction

  function automatic void clear_screen_model();
    for (int i = 0; i < CELLS; i++) screen_model[i] = blank_word();
    cur_col = 0;
    cur_row = 0;
  endfunction

  // returns 1 when the put ran off the bottom row and scrolled
  function automatic bit console_put(logic [CHAR_W-1:0] ch);
    if (ch == CH_NEWLINE) begin
      cur_col = 0;
      cur_row++;
    end else if (ch == CH_RETURN) begin
      cur_col = 0;
    end else if (ch == CH_BACKSPACE) begin
      if (cur_col > 0) begin
        cur_col--;
        screen_model[cur_row * COLUMNS + cur_col] = blank_word();
      end
    end else begin
      screen_model[cur_row * COLUMNS + cur_col] = {attr_model, ch};
      cur_col++;
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_row++;
      end
    end
    if (cur_row < ROWS) return 1'b0;
    for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = blank_word();
    cur_row = ROWS - 1;
    return 1'b1;
  endfunction

  function automatic console_result_t console_apply(console_item_t it);
    console_result_t r;
    r = '0;
    case (it.opcode)
      OP_PUT: begin
        r.scrolled = console_put(it.char_code);
      end
      OP_CLEAR: begin
        clear_screen_model();
      end
      OP_READ: begin
        if (it.read_row < ROWS && it.read_col < COLUMNS)
          r.cell_word = screen_model[it.read_row * COLUMNS + it.read_col];
      end
      default: ;
    endcase
    r.cursor_col = CUR_COL_W'(cur_col);
    r.cursor_row = CUR_ROW_W'(cur_row);
    return r;
  endfunction

  function automatic void add_row(logic [OPCODE_W-1:0] op, logic [CHAR_W-1:0] ch,
                                  logic [RD_ROW_W-1:0] row, logic [RD_COL_W-1:0] col,
                                  int reps, bit known, logic [WORD_W-1:0] word,
                                  logic [CUR_COL_W-1:0] ccol, logic [CUR_ROW_W-1:0] crow,
                                  logic scr);
    stim_row_t s;
    s.item  = '{opcode: op, char_code: ch, read_row: row, read_col: col};
    s.reps  = reps;
    s.known = known;
    s.res   = '{cell_word: word, cursor_col: ccol, cursor_row: crow, scrolled: scr};
    stim_rows.push_back(s);
  endfunction

  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [RD_ROW_W-1:0] row, input logic [RD_COL_W-1:0] col,
                           input bit known, input console_result_t res);
    while (!calm && $urandom_range(99) < 6) begin
      char_if.valid <= 1'b0;
      @(posedge clk);
    end
    char_if.valid     <= 1'b1;
    char_if.opcode    <= op;
    char_if.char_code <= ch;
    char_if.read_row  <= row;
    char_if.read_col  <= col;
    row_known         <= known;
    row_expect        <= res;
    @(posedge clk);
    while (!char_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_item(OP_PUT, ch, RD_ROW_W'($urandom), RD_COL_W'($urandom), 1'b0, '0);
  endtask

  task automatic wait_drained();
    char_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_attribute(input logic [ATTR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    attr_model = value;
    @(posedge clk);
  endtask

  // one burst of related traffic: a text line, a newline run, backspaces,
  // reads around the cursor, or raw noise
  task automatic run_segment();
    int                  kind;
    int                  len;
    int                  r;
    logic [CHAR_W-1:0]   ch;
    logic [RD_ROW_W-1:0] row;
    logic [RD_COL_W-1:0] col;
    logic [OPCODE_W-1:0] op;
    kind = $urandom_range(99);
    if (kind < 30) begin
      r = $urandom_range(9);
      if (r < 7) len = $urandom_range(8);
      else if (r < 9) len = $urandom_range(79, 9);
      else len = $urandom_range(170, 80);
      repeat (len) begin
        if ($urandom_range(4) == 0) ch = CHAR_W'($urandom);
        else ch = CHAR_W'($urandom_range(8'h7E, 8'h20));
        put_char(ch);
      end
      r = $urandom_range(9);
      if (r < 3) put_char(CH_RETURN);
      if (r < 9) put_char(CH_NEWLINE);
    end else if (kind < 50) begin
      repeat ($urandom_range(20, 1)) put_char(CH_NEWLINE);
    end else if (kind < 60) begin
      repeat ($urandom_range(10, 1)) put_char(CH_BACKSPACE);
    end else if (kind < 80) begin
      repeat ($urandom_range(8, 1)) begin
        r = $urandom_range(9);
        if (r < 7) begin
          row = (cur_row > 0 && $urandom_range(1) == 1) ? RD_ROW_W'(cur_row - 1)
                                                        : RD_ROW_W'(cur_row);
          col = RD_COL_W'($urandom_range(COLUMNS - 1));
        end else if (r < 9) begin
          row = RD_ROW_W'($urandom_range(ROWS - 1));
          col = RD_COL_W'($urandom_range(COLUMNS - 1));
        end else begin
          row = RD_ROW_W'($urandom);
          col = RD_COL_W'($urandom);
        end
        send_item(OP_READ, CHAR_W'($urandom), row, col, 1'b0, '0);
      end
    end else begin
      repeat ($urandom_range(8, 1)) begin
        r = $urandom_range(19);
        if (r == 0) op = OP_CLEAR;
        else if (r < 8) op = OP_PUT;
        else if (r < 14) op = OP_READ;
        else op = OP_UNUSED;
        send_item(op, CHAR_W'($urandom), RD_ROW_W'($urandom), RD_COL_W'($urandom),
                  1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    resp_if.ready <= calm || ($urandom_range(99) >= 6);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (resp_if.valid && resp_if.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with no expectation pending");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (resp_if.cell_word !== want.cell_word) begin
            $error("cell_word: expected %h, got %h", want.cell_word, resp_if.cell_word);
            fail_count++;
          end
          if (resp_if.cursor_col !== want.cursor_col) begin
            $error("cursor_col: expected %0d, got %0d", want.cursor_col, resp_if.cursor_col);
            fail_count++;
          end
          if (resp_if.cursor_row !== want.cursor_row) begin
            $error("cursor_row: expected %0d, got %0d", want.cursor_row, resp_if.cursor_row);
            fail_count++;
          end
          if (resp_if.scrolled !== want.scrolled) begin
            $error("scrolled: expected %b, got %b", want.scrolled, resp_if.scrolled);
            fail_count++;
          end
        end
      end
      if (char_if.valid && char_if.ready) begin
        seen.opcode    = char_if.opcode;
        seen.char_code = char_if.char_code;
        seen.read_row  = char_if.read_row;
        seen.read_col  = char_if.read_col;
        got = console_apply(seen);
        expected_q.push_back(row_known ? row_expect : got);
      end
    end
  end

  initial begin : stimulus
    int phase_end;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    char_if.valid     <= 1'b0;
    char_if.opcode    <= OP_PUT;
    char_if.char_code <= '0;
    char_if.read_row  <= '0;
    char_if.read_col  <= '0;
    row_known         <= 1'b0;
    row_expect        <= '0;
    attr_model = ATTR_RESET;
    clear_screen_model();

    // op, char, row, col, reps, known, word, col, row, scrolled
    add_row(OP_READ, 8'h00, 5'd0, 7'd0, 1, 1'b1, 16'h0720, 7'd0, 5'd0, 1'b0);
    add_row(OP_READ, 8'h00, 5'd24, 7'd79, 1, 1'b1, 16'h0720, 7'd0, 5'd0, 1'b0);
    add_row(OP_READ, 8'h00, 5'd25, 7'd0, 1, 1'b1, 16'h0000, 7'd0, 5'd0, 1'b0);
    add_row(OP_READ, 8'h00, 5'd0, 7'd80, 1, 1'b1, 16'h0000, 7'd0, 5'd0, 1'b0);
    add_row(OP_READ, 8'hFF, 5'd31, 7'd127, 1, 1'b1, 16'h0000, 7'd0, 5'd0, 1'b0);
    add_row(OP_UNUSED, 8'hFF, 5'd31, 7'd127, 1, 1'b1, 16'h0000, 7'd0, 5'd0, 1'b0);
    // backspace at column 0 leaves everything alone
    add_row(OP_PUT, CH_BACKSPACE, 5'd0, 7'd0, 1, 1'b1, 16'h0000, 7'd0, 5'd0, 1'b0);
    add_row(OP_PUT, 8'hFF, 5'd31, 7'd127, 1, 1'b1, 16'h0000, 7'd1, 5'd0, 1'b0);
    add_row(OP_PUT, 8'h00, 5'd0, 7'd0, 1, 1'b1, 16'h0000, 7'd2, 5'd0, 1'b0);
    add_row(OP_READ, 8'h00, 5'd0, 7'd0, 1, 1'b1, 16'h07FF, 7'd2, 5'd0, 1'b0);
    add_row(OP_READ, 8'h00, 5'd0, 7'd1, 1, 1'b1, 16'h0700, 7'd2, 5'd0, 1'b0);
    add_row(OP_PUT, CH_BACKSPACE, 5'd0, 7'd0, 1, 1'b1, 16'h0000, 7'd1, 5'd0, 1'b0);
    add_row(OP_READ, 8'h00, 5'd0, 7'd1, 1, 1'b1, 16'h0720, 7'd1, 5'd0, 1'b0);
    add_row(OP_PUT, CH_RETURN, 5'd0, 7'd0, 1, 1'b1, 16'h0000, 7'd0, 5'd0, 1'b0);
    add_row(OP_PUT, CH_NEWLINE, 5'd0, 7'd0, 1, 1'b1, 16'h0000, 7'd0, 5'd1, 1'b0);
    add_row(OP_PUT, 8'h41, 5'd0, 7'd0, 1, 1'b0, '0, '0, '0, 1'b0);
    add_row(OP_CLEAR, 8'hFF, 5'd31, 7'd127, 1, 1'b1, 16'h0000, 7'd0, 5'd0, 1'b0);
    add_row(OP_READ, 8'h00, 5'd1, 7'd0, 1, 1'b1, 16'h0720, 7'd0, 5'd0, 1'b0);
    // walk down to the bottom row, then scroll on a newline
    add_row(OP_PUT, CH_NEWLINE, 5'd0, 7'd0, 24, 1'b0, '0, '0, '0, 1'b0);
    add_row(OP_PUT, 8'h5A, 5'd0, 7'd0, 1, 1'b0, '0, '0, '0, 1'b0);
    add_row(OP_PUT, CH_NEWLINE, 5'd0, 7'd0, 1, 1'b1, 16'h0000, 7'd0, 5'd24, 1'b1);
    add_row(OP_READ, 8'h00, 5'd23, 7'd0, 1, 1'b1, 16'h075A, 7'd0, 5'd24, 1'b0);
    add_row(OP_READ, 8'h00, 5'd24, 7'd0, 1, 1'b1, 16'h0720, 7'd0, 5'd24, 1'b0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      repeat (stim_rows[i].reps)
        send_item(stim_rows[i].item.opcode, stim_rows[i].item.char_code,
                  stim_rows[i].item.read_row, stim_rows[i].item.read_col,
                  stim_rows[i].known, stim_rows[i].res);
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      wait_drained();
      if (phase == 0) set_attribute(8'hFF);
      else if (phase == 1) set_attribute(8'h00);
      else set_attribute(ATTR_W'($urandom));
      calm = (phase == 3);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) run_segment();
    end
    calm = 1'b0;

    wait_drained();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("[text_console_writer_top] OK");
    end else begin
      $display("[text_console_writer_top] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
sv/tcw_pkg.sv
sv/tcw_in_if.sv
sv/tcw_out_if.sv
sv/tcw_ram.sv
sv/tcw_ctrl.sv
sv/tcw_datapath.sv
sv/text_console_writer_top.sv
tb/text_console_writer_top_test.sv
